FILE: hdl/adaptive_non_maximal_suppression_unit_macros.svh
// assertion macros used by the checker file
`ifndef ADAPTIVE_NON_MAXIMAL_SUPPRESSION_UNIT_MACROS_SVH
`define ADAPTIVE_NON_MAXIMAL_SUPPRESSION_UNIT_MACROS_SVH

// checked only while out of reset
`define ANMS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("anms check failed");

// checked on every edge, reset included
`define ANMS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("anms check failed");

`endif

FILE: hdl/anms_pkg.sv
// shared types and constants of the suppression unit
package anms_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int COORD_BITS_DEF = 12;
    localparam int XY_W           = 12;
    localparam int STR_W          = 16;
    localparam int KEEP_W         = 11;
    localparam int PCT_W          = 8;
    localparam int CFG_DATA_W     = 11;
    localparam int CFG_IDX_W      = 1;
    // wide enough for any point count or keep count
    localparam int CMP_W          = 16;
    localparam int LIM_W          = STR_W + PCT_W;

    localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(1000);
    localparam logic [PCT_W-1:0]  PCT_RESET  = PCT_W'(111);
    localparam logic [6:0]        PCT_UNIT   = 7'd100;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_READ = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEEP_COUNT = 1'b0,
        CFG_ROBUST_PCT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic             opcode;
        logic [XY_W-1:0]  point_x;
        logic [XY_W-1:0]  point_y;
        logic [STR_W-1:0] strength;
    } t_in_item;

    typedef struct packed {
        logic [XY_W-1:0]  out_x;
        logic [XY_W-1:0]  out_y;
        logic [STR_W-1:0] out_strength;
        logic             last;
        logic             none_left;
    } t_out_item;

    typedef struct packed {
        logic busy;
        logic done;
    } t_sel_status;

    typedef enum logic [1:0] {
        T_IDLE,
        T_SELECT,
        T_RD_ISSUE,
        T_RD_WAIT
    } t_top_state;

    typedef enum logic [3:0] {
        S_IDLE,
        S_P1_FETCH,
        S_P1_HOLD,
        S_P1_SCAN,
        S_P1_DRAIN,
        S_P2_FETCH,
        S_P2_HOLD,
        S_P2_SCAN,
        S_P2_DRAIN,
        S_P3_SCAN,
        S_P3_DRAIN,
        S_DONE
    } t_sel_state;

endpackage

FILE: hdl/anms_chan_if.sv
// valid/ready channel carrying one payload
interface anms_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/anms_ram.sv
// generic simple dual port ram with registered read
module anms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/anms_select.sv
// selection engine: rank and radius pass, threshold pass, last-kept pass
module anms_select #(
    parameter int MAX_POINTS = anms_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = anms_pkg::COORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [$clog2(MAX_POINTS+1)-1:0]       i_count,
    input  logic [anms_pkg::KEEP_W-1:0]           i_keep,
    input  logic [anms_pkg::PCT_W-1:0]            i_pct,
    output logic [$clog2(MAX_POINTS)-1:0]         o_a_raddr,
    input  logic [2*COORD_BITS+anms_pkg::STR_W-1:0] i_a_rdata,
    output logic [$clog2(MAX_POINTS)-1:0]         o_b_raddr,
    input  logic [4*COORD_BITS+anms_pkg::STR_W:0] i_b_rdata,
    output logic                                  o_b_we,
    output logic [$clog2(MAX_POINTS)-1:0]         o_b_waddr,
    output logic [4*COORD_BITS+anms_pkg::STR_W:0] o_b_wdata,
    output anms_pkg::t_sel_status                 o_status,
    output logic [2*COORD_BITS:0]                 o_threshold,
    output logic [$clog2(MAX_POINTS)-1:0]         o_last_idx
);
    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CW    = $clog2(MAX_POINTS+1);
    localparam int SW    = anms_pkg::STR_W;
    localparam int PW    = 2*COORD_BITS + SW;
    localparam int RW    = 2*COORD_BITS + 1;
    localparam int LW    = anms_pkg::LIM_W;
    localparam int KW    = anms_pkg::CMP_W;
    localparam logic [RW-1:0] RADIUS_NONE = {RW{1'b1}};

    anms_pkg::t_sel_state r_state, n_state;

    logic [CW-1:0]         r_n, r_i, r_j;
    logic [anms_pkg::KEEP_W-1:0] r_k;
    logic [anms_pkg::PCT_W-1:0]  r_pct;
    logic                  r_v1, r_v2, r_v3;
    logic [AW-1:0]         r_j1;
    logic [PW-1:0]         r_pi;
    logic [LW-1:0]         r_lim;
    logic                  r_cand2, r_earl2, r_cand3, r_earl3;
    logic [COORD_BITS-1:0] r_dx, r_dy;
    logic [2*COORD_BITS-1:0] r_dx2, r_dy2;
    logic [RW-1:0]         r_min, r_ri, r_thr;
    logic [AW-1:0]         r_rank, r_last;
    logic [CW-1:0]         r_cgt, r_cge;

    logic          issue, b_we, done, pipe_busy, last_i, last_j;
    logic          in_p1, in_p2, in_p3;
    logic [AW-1:0] a_raddr, b_raddr;
    logic [CW-1:0] last_n;

    // fields of the scanned point j, the held point i and the radius from the sorted store
    logic [SW-1:0]         sj, si;
    logic [COORD_BITS-1:0] xj, yj, xi, yi;
    logic [RW-1:0]         rj;
    logic                  earlier, stronger;
    logic [RW-1:0]         dsum;

    assign last_n    = r_n - CW'(1);
    assign last_i    = (r_i == last_n);
    assign last_j    = (r_j == last_n);
    assign pipe_busy = r_v1 | r_v2 | r_v3;
    assign in_p1     = (r_state == anms_pkg::S_P1_SCAN) || (r_state == anms_pkg::S_P1_DRAIN);
    assign in_p2     = (r_state == anms_pkg::S_P2_SCAN) || (r_state == anms_pkg::S_P2_DRAIN);
    assign in_p3     = (r_state == anms_pkg::S_P3_SCAN) || (r_state == anms_pkg::S_P3_DRAIN);

    assign sj = i_a_rdata[PW-1 -: SW];
    assign yj = i_a_rdata[2*COORD_BITS-1 -: COORD_BITS];
    assign xj = i_a_rdata[COORD_BITS-1:0];
    assign si = r_pi[PW-1 -: SW];
    assign yi = r_pi[2*COORD_BITS-1 -: COORD_BITS];
    assign xi = r_pi[COORD_BITS-1:0];
    assign rj = i_b_rdata[RW-1:0];

    // earlier in the stable descending order
    assign earlier  = (sj > si) || ((sj == si) && (CW'(r_j1) < r_i));
    assign stronger = (LW'(sj) * LW'(anms_pkg::PCT_UNIT)) > r_lim;
    assign dsum     = RW'(r_dx2) + RW'(r_dy2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= anms_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        a_raddr = r_i[AW-1:0];
        b_raddr = r_i[AW-1:0];
        issue   = 1'b0;
        b_we    = 1'b0;
        done    = 1'b0;
        case (r_state)
            anms_pkg::S_IDLE: begin
                if (i_start) n_state = anms_pkg::S_P1_FETCH;
            end
            anms_pkg::S_P1_FETCH: n_state = anms_pkg::S_P1_HOLD;
            anms_pkg::S_P1_HOLD:  n_state = anms_pkg::S_P1_SCAN;
            anms_pkg::S_P1_SCAN: begin
                a_raddr = r_j[AW-1:0];
                issue   = 1'b1;
                if (last_j) n_state = anms_pkg::S_P1_DRAIN;
            end
            anms_pkg::S_P1_DRAIN: begin
                if (!pipe_busy) begin
                    b_we    = 1'b1;
                    n_state = last_i ? anms_pkg::S_P2_FETCH : anms_pkg::S_P1_FETCH;
                end
            end
            anms_pkg::S_P2_FETCH: n_state = anms_pkg::S_P2_HOLD;
            anms_pkg::S_P2_HOLD:  n_state = anms_pkg::S_P2_SCAN;
            anms_pkg::S_P2_SCAN: begin
                b_raddr = r_j[AW-1:0];
                issue   = 1'b1;
                if (last_j) n_state = anms_pkg::S_P2_DRAIN;
            end
            anms_pkg::S_P2_DRAIN: begin
                if (!r_v1) begin
                    n_state = last_i ? anms_pkg::S_P3_SCAN : anms_pkg::S_P2_FETCH;
                end
            end
            anms_pkg::S_P3_SCAN: begin
                b_raddr = r_j[AW-1:0];
                issue   = 1'b1;
                if (last_j) n_state = anms_pkg::S_P3_DRAIN;
            end
            anms_pkg::S_P3_DRAIN: begin
                if (!r_v1) n_state = anms_pkg::S_DONE;
            end
            anms_pkg::S_DONE: begin
                done    = 1'b1;
                n_state = anms_pkg::S_IDLE;
            end
            default: n_state = anms_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1 && in_p1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j1 <= r_j[AW-1:0];
        if (issue) r_j <= r_j + CW'(1);

        case (r_state)
            anms_pkg::S_IDLE: begin
                r_n   <= i_count;
                r_k   <= (i_keep == '0) ? anms_pkg::KEEP_W'(1) : i_keep;
                r_pct <= i_pct;
                r_i   <= '0;
                r_thr <= '0;
                r_last <= '0;
            end
            anms_pkg::S_P1_FETCH: begin
                r_j    <= '0;
                r_min  <= RADIUS_NONE;
                r_rank <= '0;
            end
            anms_pkg::S_P1_HOLD: begin
                r_pi  <= i_a_rdata;
                r_lim <= LW'(i_a_rdata[PW-1 -: SW]) * LW'(r_pct);
            end
            anms_pkg::S_P1_DRAIN: begin
                if (!pipe_busy) r_i <= last_i ? '0 : r_i + CW'(1);
            end
            anms_pkg::S_P2_FETCH: begin
                r_j   <= '0;
                r_cgt <= '0;
                r_cge <= '0;
            end
            anms_pkg::S_P2_HOLD: begin
                r_ri <= rj;
            end
            anms_pkg::S_P2_DRAIN: begin
                if (!r_v1) begin
                    // radius whose rank brackets keep_count is the threshold
                    if ((KW'(r_cgt) < KW'(r_k)) && (KW'(r_cge) >= KW'(r_k))) begin
                        r_thr <= r_ri;
                    end
                    r_i <= r_i + CW'(1);
                    if (last_i) r_j <= '0;
                end
            end
            default: ;
        endcase

        // rank and radius pipeline
        if (r_v1 && in_p1) begin
            r_cand2 <= earlier && stronger;
            r_earl2 <= earlier;
            r_dx    <= (xi > xj) ? xi - xj : xj - xi;
            r_dy    <= (yi > yj) ? yi - yj : yj - yi;
        end
        if (r_v2) begin
            r_cand3 <= r_cand2;
            r_earl3 <= r_earl2;
            r_dx2   <= (2*COORD_BITS)'(r_dx) * (2*COORD_BITS)'(r_dx);
            r_dy2   <= (2*COORD_BITS)'(r_dy) * (2*COORD_BITS)'(r_dy);
        end
        if (r_v3) begin
            if (r_cand3 && (dsum < r_min)) r_min <= dsum;
            if (r_earl3) r_rank <= r_rank + AW'(1);
        end

        if (r_v1 && in_p2) begin
            if (rj > r_ri)  r_cgt <= r_cgt + CW'(1);
            if (rj >= r_ri) r_cge <= r_cge + CW'(1);
        end
        if (r_v1 && in_p3) begin
            if (rj >= r_thr) r_last <= r_j1;
        end
    end

    assign o_a_raddr       = a_raddr;
    assign o_b_raddr       = b_raddr;
    assign o_b_we          = b_we;
    assign o_b_waddr       = r_rank;
    assign o_b_wdata       = {r_pi, r_min};
    assign o_status.busy   = (r_state != anms_pkg::S_IDLE);
    assign o_status.done   = done;
    assign o_threshold     = r_thr;
    assign o_last_idx      = r_last;
endmodule

FILE: hdl/adaptive_non_maximal_suppression_unit.sv
// adaptive non-maximal suppression unit, top level
//
// i_item_ch carries load and read transactions, o_result_ch one result per read.
// A load produces no result; it is dropped when the store is
// full or while a selected set is being read out.
// The first read of a set with more points than keep_count runs the selection
// engine over the two point memories: a rank/radius pass, a threshold pass
// and a last-kept pass. With at most keep_count points no selection runs.
// Each read steps over every dropped point before it answers.
// A read on an empty store answers with none_left.
// Results sit in an output register; loads are still taken while it waits, a
// read waits until the result register is free.
// Synchronous reset empties the set and loads the configuration defaults; the
// memories are not cleared and need no clearing pass.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data.
module adaptive_non_maximal_suppression_unit #(
    parameter int MAX_POINTS = anms_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = anms_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [anms_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [anms_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    anms_chan_if.sink                         i_item_ch,
    anms_chan_if.source                       o_result_ch
);
    localparam int AW  = $clog2(MAX_POINTS);
    localparam int CW  = $clog2(MAX_POINTS+1);
    localparam int SW  = anms_pkg::STR_W;
    localparam int PW  = 2*COORD_BITS + SW;
    localparam int RW  = 2*COORD_BITS + 1;
    localparam int BW  = PW + RW;
    localparam int XYW = anms_pkg::XY_W;
    localparam int KW  = anms_pkg::CMP_W;

    anms_pkg::t_top_state r_state, n_state;
    anms_pkg::t_in_item   item;
    anms_pkg::t_out_item  r_out, out_item;
    anms_pkg::t_sel_status sel_status;

    logic [CW-1:0]               r_count, r_rp;
    logic                        r_sel_done, r_direct, r_out_valid;
    logic [RW-1:0]               r_thr;
    logic [AW-1:0]               r_last_idx;
    logic [anms_pkg::KEEP_W-1:0] r_keep;
    logic [anms_pkg::PCT_W-1:0]  r_pct;

    logic          in_acc, is_read, load_ok, few_points, sel_start, out_set;
    logic          a_we, b_we, rd_last, rd_drop;
    logic [AW-1:0] a_raddr, b_raddr, sel_a_raddr, sel_b_raddr, b_waddr;
    logic [PW-1:0] a_rdata, a_wdata, rd_point;
    logic [BW-1:0] b_rdata, b_wdata;
    logic [RW-1:0] sel_thr;
    logic [AW-1:0] sel_last;
    logic [anms_pkg::KEEP_W-1:0] keep_eff;

    assign item       = i_item_ch.data;
    assign is_read    = (item.opcode == anms_pkg::OP_READ);
    assign in_acc     = i_item_ch.valid && i_item_ch.ready;
    assign load_ok    = !r_sel_done && (r_count < CW'(MAX_POINTS));
    assign keep_eff   = (r_keep == '0) ? anms_pkg::KEEP_W'(1) : r_keep;
    assign few_points = KW'(r_count) <= KW'(keep_eff);

    assign a_we    = in_acc && !is_read && load_ok;
    assign a_wdata = {item.strength, COORD_BITS'(item.point_y), COORD_BITS'(item.point_x)};

    assign rd_point = r_direct ? a_rdata : b_rdata[BW-1 -: PW];
    assign rd_drop  = !r_direct && (b_rdata[RW-1:0] < r_thr);
    assign rd_last  = r_direct ? (r_rp == r_count - CW'(1)) : (r_rp[AW-1:0] == r_last_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= anms_pkg::T_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        sel_start = 1'b0;
        out_set   = 1'b0;
        out_item  = '0;
        a_raddr   = sel_a_raddr;
        b_raddr   = sel_b_raddr;
        i_item_ch.ready = 1'b0;
        case (r_state)
            anms_pkg::T_IDLE: begin
                // a read needs the result register free
                i_item_ch.ready = !r_out_valid || !is_read;
                if (in_acc && is_read) begin
                    if (r_count == '0) begin
                        out_set            = 1'b1;
                        out_item.none_left = 1'b1;
                    end else if (r_sel_done || few_points) begin
                        n_state = anms_pkg::T_RD_ISSUE;
                    end else begin
                        sel_start = 1'b1;
                        n_state   = anms_pkg::T_SELECT;
                    end
                end
            end
            anms_pkg::T_SELECT: begin
                if (sel_status.done) n_state = anms_pkg::T_RD_ISSUE;
            end
            anms_pkg::T_RD_ISSUE: begin
                a_raddr = r_rp[AW-1:0];
                b_raddr = r_rp[AW-1:0];
                if (r_rp >= r_count) begin
                    out_set            = 1'b1;
                    out_item.none_left = 1'b1;
                    n_state            = anms_pkg::T_IDLE;
                end else begin
                    n_state = anms_pkg::T_RD_WAIT;
                end
            end
            anms_pkg::T_RD_WAIT: begin
                if (rd_drop) begin
                    n_state = anms_pkg::T_RD_ISSUE;
                end else begin
                    out_set               = 1'b1;
                    out_item.out_x        = XYW'(rd_point[COORD_BITS-1:0]);
                    out_item.out_y        = XYW'(rd_point[2*COORD_BITS-1 -: COORD_BITS]);
                    out_item.out_strength = rd_point[PW-1 -: SW];
                    out_item.last         = rd_last;
                    n_state               = anms_pkg::T_IDLE;
                end
            end
            default: n_state = anms_pkg::T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rp        <= '0;
            r_sel_done  <= 1'b0;
            r_direct    <= 1'b0;
            r_thr       <= '0;
            r_last_idx  <= '0;
            r_out_valid <= 1'b0;
            r_keep      <= anms_pkg::KEEP_RESET;
            r_pct       <= anms_pkg::PCT_RESET;
        end else begin
            if (i_cfg_we) begin
                case (anms_pkg::t_cfg_idx'(i_cfg_idx))
                    anms_pkg::CFG_KEEP_COUNT: r_keep <= i_cfg_data;
                    anms_pkg::CFG_ROBUST_PCT: r_pct  <= i_cfg_data[anms_pkg::PCT_W-1:0];
                    default: ;
                endcase
            end

            if (a_we) r_count <= r_count + CW'(1);

            if (out_set) begin
                r_out_valid <= 1'b1;
            end else if (o_result_ch.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                anms_pkg::T_IDLE: begin
                    if (in_acc && is_read && (r_count != '0) && !r_sel_done) begin
                        r_rp <= '0;
                        if (few_points) begin
                            r_sel_done <= 1'b1;
                            r_direct   <= 1'b1;
                            r_thr      <= '0;
                        end else begin
                            r_direct <= 1'b0;
                        end
                    end
                end
                anms_pkg::T_SELECT: begin
                    if (sel_status.done) begin
                        r_sel_done <= 1'b1;
                        r_thr      <= sel_thr;
                        r_last_idx <= sel_last;
                    end
                end
                anms_pkg::T_RD_ISSUE: begin
                    if (r_rp >= r_count) begin
                        r_count    <= '0;
                        r_rp       <= '0;
                        r_sel_done <= 1'b0;
                        r_thr      <= '0;
                    end
                end
                anms_pkg::T_RD_WAIT: begin
                    if (!rd_drop && rd_last) begin
                        r_count    <= '0;
                        r_rp       <= '0;
                        r_sel_done <= 1'b0;
                        r_thr      <= '0;
                    end else begin
                        r_rp <= r_rp + CW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_set) r_out <= out_item;
    end

    assign o_result_ch.valid = r_out_valid;
    assign o_result_ch.data  = r_out;

    // points in arrival order
    anms_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_point_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (a_wdata),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    // points in response order with their radius
    anms_ram #(.WIDTH(BW), .DEPTH(MAX_POINTS)) u_sorted_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    anms_select #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_select (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (sel_start),
        .i_count     (r_count),
        .i_keep      (r_keep),
        .i_pct       (r_pct),
        .o_a_raddr   (sel_a_raddr),
        .i_a_rdata   (a_rdata),
        .o_b_raddr   (sel_b_raddr),
        .i_b_rdata   (b_rdata),
        .o_b_we      (b_we),
        .o_b_waddr   (b_waddr),
        .o_b_wdata   (b_wdata),
        .o_status    (sel_status),
        .o_threshold (sel_thr),
        .o_last_idx  (sel_last)
    );
endmodule

FILE: hdl/anms_checker.sv
// port-level assertions for the suppression unit
`include "adaptive_non_maximal_suppression_unit_macros.svh"

module anms_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_in_op,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input anms_pkg::t_out_item i_out_item
);
    logic rd_acc;

    assign rd_acc = i_in_valid && i_in_ready && (i_in_op == anms_pkg::OP_READ);

    `ANMS_ASSERT_ALWAYS(a_reset_no_result, i_clk, !i_rst_n |=> !i_out_valid)

    `ANMS_ASSERT(a_result_held, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_item))

    // no two read transactions accepted back to back
    `ANMS_ASSERT(a_one_read, i_clk, i_rst_n, rd_acc |=> !rd_acc)

    `ANMS_ASSERT(a_empty_clean, i_clk, i_rst_n, i_out_valid && i_out_item.none_left |-> i_out_item.out_x == '0 && i_out_item.out_y == '0 && i_out_item.out_strength == '0 && !i_out_item.last)
endmodule

bind adaptive_non_maximal_suppression_unit anms_checker u_anms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item_ch.valid),
    .i_in_ready  (i_item_ch.ready),
    .i_in_op     (i_item_ch.data.opcode),
    .i_out_valid (o_result_ch.valid),
    .i_out_ready (o_result_ch.ready),
    .i_out_item  (o_result_ch.data)
);
